[hdl/bvs_pkg.sv]
// Shared constants, codes and types of the bounding-box visual servo step core.
package bvs_pkg;

    localparam int CMD_BITS       = 16;
    localparam int CTR_BITS       = 12;
    localparam int LIM_BITS       = 15;
    localparam int LOSS_BITS      = 8;
    localparam int TOL_BITS       = 9;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam int DIV_Q_BITS     = LIM_BITS;
    localparam int DIV_D_BITS     = CTR_BITS;
    localparam int DIV_N_BITS     = DIV_Q_BITS + DIV_D_BITS;
    localparam int DIV_CNT_BITS   = 4;

    localparam int DB_RECIP       = 683;
    localparam int DB_SHIFT       = 11;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_TRACK  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_YAW     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CLIMB   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOST_TICKS  = 3'd4;

    localparam logic [CTR_BITS-1:0]  RST_HALF_WIDTH  = 12'd320;
    localparam logic [CTR_BITS-1:0]  RST_HALF_HEIGHT = 12'd240;
    localparam logic [LIM_BITS-1:0]  RST_MAX_YAW     = 15'd4289;
    localparam logic [LIM_BITS-1:0]  RST_MAX_CLIMB   = 15'd1229;
    localparam logic [LOSS_BITS-1:0] RST_LOST_TICKS  = 8'd10;

    localparam logic signed [CMD_BITS-1:0] SEARCH_YAW = 16'sd643;

    typedef struct packed {
        logic                  start;
        logic [DIV_N_BITS-1:0] dividend;
        logic [DIV_D_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_Q_BITS-1:0] quotient;
    } div_rsp_t;

    // centre / 12 computed as (centre / 4) / 3 with a reciprocal multiply
    function automatic logic [TOL_BITS-1:0] deadband_tol(input logic [CTR_BITS-1:0] ctr);
        logic [19:0] prod;
        prod = 20'(ctr[CTR_BITS-1:2]) * 20'(DB_RECIP);
        return prod[19:DB_SHIFT];
    endfunction

endpackage

[hdl/bvs_if.sv]
// Handshake channel interfaces: detection box in, command out, configuration write.
interface bvs_det_if #(parameter int COORD_BITS = 14);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic signed [COORD_BITS-1:0] box_right;
    logic signed [COORD_BITS-1:0] box_bottom;

    modport source (output valid, box_left, box_top, box_right, box_bottom, input ready);
    modport sink   (input valid, box_left, box_top, box_right, box_bottom, output ready);
endinterface

interface bvs_cmd_if #(parameter int COORD_BITS = 14);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [15:0]           yaw_cmd;
    logic signed [15:0]           climb_cmd;
    logic signed [COORD_BITS-1:0] target_col;
    logic signed [COORD_BITS-1:0] target_row;
    logic                         turn_left;

    modport source (output valid, action, yaw_cmd, climb_cmd, target_col, target_row,
                    turn_left, input ready);
    modport sink   (input valid, action, yaw_cmd, climb_cmd, target_col, target_row,
                    turn_left, output ready);
endinterface

interface bvs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/bbox_visual_servo_step_core.sv]
// Top level of the bounding-box visual servo step core.
// One detection box per control tick produces one command transaction. A tick
// without a box is clamped after acceptance and then loads the output register.
// A tick with a box runs clamp, centre, then per axis a multiply step and the
// shared 15-step divider (load, 15 steps, result), or a single step for an axis
// inside its dead band or at saturation, and a last step to load the output
// register, which waits while the output is stalled. The divider sets the rate.
// det.ready returns in the same cycle as the loaded command appears.
// det.ready is high only while no tick is in progress; a finished command
// waits in its output register while the next box is taken. Configuration
// writes are taken in any cycle and must only occur while the core is idle.
module bbox_visual_servo_step_core #(
    parameter int COORD_BITS = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    bvs_det_if.sink   det,
    bvs_cmd_if.source cmd,
    bvs_cfg_if.sink   cfg
);
    import bvs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = ((CB > 13) ? CB : 13) + 2;
    localparam int MW = EW - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_CENTER,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    logic [CTR_BITS-1:0]  half_width_reg, half_height_reg;
    logic [LIM_BITS-1:0]  max_yaw_reg, max_climb_reg;
    logic [LOSS_BITS-1:0] lost_ticks_reg;

    state_t               state_reg, state_next;
    logic                 tracking_reg, tracking_next;
    logic [LOSS_BITS-1:0] loss_count_reg, loss_count_next;
    logic                 search_ccw_reg, search_ccw_next;
    logic                 axis_reg, axis_next;
    logic                 div_start_reg, div_start_next;

    logic signed [CB-1:0] left_reg, left_next, top_reg, top_next;
    logic signed [CB-1:0] right_reg, right_next, bottom_reg, bottom_next;
    logic [TOL_BITS-1:0]  tolx_reg, tolx_next, toly_reg, toly_next;
    logic [MW-1:0]        errx_reg, errx_next, erry_reg, erry_next;
    logic                 yaw_act_reg, yaw_act_next, yaw_neg_reg, yaw_neg_next;
    logic                 clb_act_reg, clb_act_next, clb_neg_reg, clb_neg_next;
    logic [DIV_N_BITS-1:0] prod_reg, prod_next;

    logic [1:0]                  res_action_reg, res_action_next;
    logic signed [CMD_BITS-1:0]  res_yaw_reg, res_yaw_next;
    logic signed [CMD_BITS-1:0]  res_climb_reg, res_climb_next;
    logic signed [CB-1:0]        res_col_reg, res_col_next;
    logic signed [CB-1:0]        res_row_reg, res_row_next;

    logic                        cmd_valid_reg, cmd_valid_next;
    logic [1:0]                  cmd_action_reg, cmd_action_next;
    logic signed [CMD_BITS-1:0]  cmd_yaw_reg, cmd_yaw_next;
    logic signed [CMD_BITS-1:0]  cmd_climb_reg, cmd_climb_next;
    logic signed [CB-1:0]        cmd_col_reg, cmd_col_next;
    logic signed [CB-1:0]        cmd_row_reg, cmd_row_next;
    logic                        cmd_turn_reg, cmd_turn_next;

    logic signed [EW-1:0] two_hw_ext, two_hh_ext, hw_ext, hh_ext;
    logic signed [EW-1:0] right_ext, bottom_ext;
    logic signed [CB-1:0] left_c, top_c, right_c, bottom_c;
    logic                 present;
    logic signed [CB:0]   sum_x, sum_y, adj_x, adj_y;
    logic signed [EW-1:0] col_ext, row_ext, ex, ey, tolx_ext, toly_ext;
    logic [LIM_BITS-1:0]  lim;
    logic [MW-1:0]        err;
    logic [CTR_BITS-1:0]  ctr;
    logic                 act, neg, sat;
    logic [LIM_BITS-1:0]  mag;
    logic signed [CMD_BITS-1:0] signed_mag;
    logic                 trk_tmp;
    logic [LOSS_BITS-1:0] lc_tmp;

    div_req_t div_req;
    div_rsp_t div_rsp;

    bvs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = axis_reg ? half_height_reg : half_width_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= RST_HALF_WIDTH;
            half_height_reg <= RST_HALF_HEIGHT;
            max_yaw_reg     <= RST_MAX_YAW;
            max_climb_reg   <= RST_MAX_CLIMB;
            lost_ticks_reg  <= RST_LOST_TICKS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HALF_WIDTH:  half_width_reg  <= cfg.data[CTR_BITS-1:0];
                REG_HALF_HEIGHT: half_height_reg <= cfg.data[CTR_BITS-1:0];
                REG_MAX_YAW:     max_yaw_reg     <= cfg.data[LIM_BITS-1:0];
                REG_MAX_CLIMB:   max_climb_reg   <= cfg.data[LIM_BITS-1:0];
                REG_LOST_TICKS:  lost_ticks_reg  <= cfg.data[LOSS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        two_hw_ext = $signed({{(EW-CTR_BITS-1){1'b0}}, half_width_reg, 1'b0});
        two_hh_ext = $signed({{(EW-CTR_BITS-1){1'b0}}, half_height_reg, 1'b0});
        hw_ext     = $signed({{(EW-CTR_BITS){1'b0}}, half_width_reg});
        hh_ext     = $signed({{(EW-CTR_BITS){1'b0}}, half_height_reg});
        right_ext  = $signed({{(EW-CB){right_reg[CB-1]}}, right_reg});
        bottom_ext = $signed({{(EW-CB){bottom_reg[CB-1]}}, bottom_reg});

        left_c   = left_reg[CB-1] ? '0 : left_reg;
        top_c    = top_reg[CB-1] ? '0 : top_reg;
        right_c  = (right_ext > two_hw_ext) ? two_hw_ext[CB-1:0] : right_reg;
        bottom_c = (bottom_ext > two_hh_ext) ? two_hh_ext[CB-1:0] : bottom_reg;
        present  = (left_c != '0) || (top_c != '0) || (right_c != '0) || (bottom_c != '0);

        sum_x   = {1'b0, left_reg} + {right_reg[CB-1], right_reg};
        sum_y   = {1'b0, top_reg} + {bottom_reg[CB-1], bottom_reg};
        adj_x   = sum_x + {{CB{1'b0}}, sum_x[CB]};
        adj_y   = sum_y + {{CB{1'b0}}, sum_y[CB]};
        col_ext = $signed({{(EW-CB){adj_x[CB]}}, adj_x[CB:1]});
        row_ext = $signed({{(EW-CB){adj_y[CB]}}, adj_y[CB:1]});
        ex      = col_ext - hw_ext;
        ey      = hh_ext - row_ext;
        tolx_ext = $signed({{(EW-TOL_BITS){1'b0}}, tolx_reg});
        toly_ext = $signed({{(EW-TOL_BITS){1'b0}}, toly_reg});

        lim = axis_reg ? max_climb_reg : max_yaw_reg;
        err = axis_reg ? erry_reg : errx_reg;
        ctr = axis_reg ? half_height_reg : half_width_reg;
        act = axis_reg ? clb_act_reg : yaw_act_reg;
        neg = axis_reg ? clb_neg_reg : yaw_neg_reg;
        sat = (ctr == '0) || (err >= {{(MW-CTR_BITS){1'b0}}, ctr});
        mag = (state_reg == ST_DIV) ? div_rsp.quotient : lim;
        signed_mag = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_comb
    begin
        state_next      = state_reg;
        tracking_next   = tracking_reg;
        loss_count_next = loss_count_reg;
        search_ccw_next = search_ccw_reg;
        axis_next       = axis_reg;
        div_start_next  = 1'b0;
        left_next       = left_reg;
        top_next        = top_reg;
        right_next      = right_reg;
        bottom_next     = bottom_reg;
        tolx_next       = tolx_reg;
        toly_next       = toly_reg;
        errx_next       = errx_reg;
        erry_next       = erry_reg;
        yaw_act_next    = yaw_act_reg;
        yaw_neg_next    = yaw_neg_reg;
        clb_act_next    = clb_act_reg;
        clb_neg_next    = clb_neg_reg;
        prod_next       = prod_reg;
        res_action_next = res_action_reg;
        res_yaw_next    = res_yaw_reg;
        res_climb_next  = res_climb_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        cmd_valid_next  = cmd_valid_reg && !cmd.ready;
        cmd_action_next = cmd_action_reg;
        cmd_yaw_next    = cmd_yaw_reg;
        cmd_climb_next  = cmd_climb_reg;
        cmd_col_next    = cmd_col_reg;
        cmd_row_next    = cmd_row_reg;
        cmd_turn_next   = cmd_turn_reg;
        trk_tmp         = tracking_reg;
        lc_tmp          = loss_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (det.valid)
                begin
                    left_next   = det.box_left;
                    top_next    = det.box_top;
                    right_next  = det.box_right;
                    bottom_next = det.box_bottom;
                    state_next  = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                left_next   = left_c;
                top_next    = top_c;
                right_next  = right_c;
                bottom_next = bottom_c;
                tolx_next   = deadband_tol(half_width_reg);
                toly_next   = deadband_tol(half_height_reg);
                if (present)
                begin
                    state_next = ST_CENTER;
                end
                else
                begin
                    if (tracking_reg)
                    begin
                        if (loss_count_reg > LOSS_BITS'(1))
                        begin
                            lc_tmp = loss_count_reg - 1'b1;
                        end
                        else
                        begin
                            lc_tmp  = '0;
                            trk_tmp = 1'b0;
                        end
                    end
                    tracking_next   = trk_tmp;
                    loss_count_next = lc_tmp;
                    res_climb_next  = '0;
                    res_col_next    = '0;
                    res_row_next    = '0;
                    if (!trk_tmp)
                    begin
                        res_action_next = ACT_SEARCH;
                        res_yaw_next    = search_ccw_reg ? SEARCH_YAW : -SEARCH_YAW;
                    end
                    else
                    begin
                        res_action_next = ACT_NONE;
                        res_yaw_next    = '0;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_CENTER:
            begin
                tracking_next   = 1'b1;
                loss_count_next = lost_ticks_reg;
                res_action_next = ACT_TRACK;
                res_yaw_next    = '0;
                res_climb_next  = '0;
                res_col_next    = adj_x[CB:1];
                res_row_next    = adj_y[CB:1];
                yaw_act_next    = 1'b0;
                yaw_neg_next    = 1'b0;
                errx_next       = '0;
                if (ex > tolx_ext)
                begin
                    yaw_act_next    = 1'b1;
                    yaw_neg_next    = 1'b1;
                    errx_next       = ex[MW-1:0];
                    search_ccw_next = 1'b0;
                end
                else if (-ex > tolx_ext)
                begin
                    yaw_act_next    = 1'b1;
                    errx_next       = MW'(-ex);
                    search_ccw_next = 1'b1;
                end
                clb_act_next = 1'b0;
                clb_neg_next = 1'b0;
                erry_next    = '0;
                if (ey > toly_ext)
                begin
                    clb_act_next = 1'b1;
                    erry_next    = ey[MW-1:0];
                end
                else if (-ey > toly_ext)
                begin
                    clb_act_next = 1'b1;
                    clb_neg_next = 1'b1;
                    erry_next    = MW'(-ey);
                end
                axis_next  = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (act && !sat)
                begin
                    prod_next      = DIV_N_BITS'(lim) * DIV_N_BITS'(err[CTR_BITS-1:0]);
                    div_start_next = 1'b1;
                    state_next     = ST_DIV;
                end
                else
                begin
                    if (act)
                    begin
                        if (axis_reg)
                            res_climb_next = signed_mag;
                        else
                            res_yaw_next = signed_mag;
                    end
                    axis_next  = 1'b1;
                    state_next = axis_reg ? ST_FINISH : ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (axis_reg)
                        res_climb_next = signed_mag;
                    else
                        res_yaw_next = signed_mag;
                    axis_next  = 1'b1;
                    state_next = axis_reg ? ST_FINISH : ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (!cmd_valid_reg || cmd.ready)
                begin
                    cmd_valid_next  = 1'b1;
                    cmd_action_next = res_action_reg;
                    cmd_yaw_next    = res_yaw_reg;
                    cmd_climb_next  = res_climb_reg;
                    cmd_col_next    = res_col_reg;
                    cmd_row_next    = res_row_reg;
                    cmd_turn_next   = search_ccw_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tracking_reg   <= 1'b0;
            loss_count_reg <= '0;
            search_ccw_reg <= 1'b1;
            axis_reg       <= 1'b0;
            div_start_reg  <= 1'b0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tracking_reg   <= tracking_next;
            loss_count_reg <= loss_count_next;
            search_ccw_reg <= search_ccw_next;
            axis_reg       <= axis_next;
            div_start_reg  <= div_start_next;
            cmd_valid_reg  <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg       <= left_next;
        top_reg        <= top_next;
        right_reg      <= right_next;
        bottom_reg     <= bottom_next;
        tolx_reg       <= tolx_next;
        toly_reg       <= toly_next;
        errx_reg       <= errx_next;
        erry_reg       <= erry_next;
        yaw_act_reg    <= yaw_act_next;
        yaw_neg_reg    <= yaw_neg_next;
        clb_act_reg    <= clb_act_next;
        clb_neg_reg    <= clb_neg_next;
        prod_reg       <= prod_next;
        res_action_reg <= res_action_next;
        res_yaw_reg    <= res_yaw_next;
        res_climb_reg  <= res_climb_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        cmd_action_reg <= cmd_action_next;
        cmd_yaw_reg    <= cmd_yaw_next;
        cmd_climb_reg  <= cmd_climb_next;
        cmd_col_reg    <= cmd_col_next;
        cmd_row_reg    <= cmd_row_next;
        cmd_turn_reg   <= cmd_turn_next;
    end

    assign det.ready      = (state_reg == ST_IDLE);
    assign cmd.valid      = cmd_valid_reg;
    assign cmd.action     = cmd_action_reg;
    assign cmd.yaw_cmd    = cmd_yaw_reg;
    assign cmd.climb_cmd  = cmd_climb_reg;
    assign cmd.target_col = cmd_col_reg;
    assign cmd.target_row = cmd_row_reg;
    assign cmd.turn_left  = cmd_turn_reg;

endmodule

[hdl/bvs_div.sv]
// Iterative restoring divider, one quotient bit per cycle, shared by both axes.
module bvs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bvs_pkg::div_req_t req,
    output bvs_pkg::div_rsp_t rsp
);
    import bvs_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] count_reg, count_next;
    logic [DIV_D_BITS-1:0]   rem_reg;
    logic [DIV_Q_BITS-1:0]   quo_reg;
    logic [DIV_D_BITS-1:0]   divisor_reg;
    logic [DIV_D_BITS:0]     trial;
    logic [DIV_D_BITS:0]     diff;
    logic                    fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_Q_BITS-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = DIV_CNT_BITS'(DIV_Q_BITS);
        end
        else if (busy_reg)
        begin
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.dividend[DIV_N_BITS-1:DIV_Q_BITS];
            quo_reg     <= req.dividend[DIV_Q_BITS-1:0];
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
            quo_reg <= {quo_reg[DIV_Q_BITS-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hdl/bvs_checker.sv]
// Port-level assertions for the servo step core and their bind to the top level.
module bvs_checker #(
    parameter int COORD_BITS = 14
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         det_valid,
    input logic                         det_ready,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic [1:0]                   action,
    input logic signed [15:0]           yaw_cmd,
    input logic signed [15:0]           climb_cmd,
    input logic signed [COORD_BITS-1:0] target_col,
    input logic signed [COORD_BITS-1:0] target_row,
    input logic                         turn_left
);
    import bvs_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid && det_ready |=> !det_ready)
        else $error("core took a second box while a tick was in progress");

    a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && action == ACT_NONE |->
            yaw_cmd == 16'sd0 && climb_cmd == 16'sd0 &&
            target_col == '0 && target_row == '0)
        else $error("empty tracking tick carries nonzero fields");

    a_search_turn: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && action == ACT_SEARCH |->
            climb_cmd == 16'sd0 &&
            ((turn_left && yaw_cmd == SEARCH_YAW) || (!turn_left && yaw_cmd == -SEARCH_YAW)))
        else $error("search turn does not follow its direction");

    a_track_direction: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && action == ACT_TRACK && yaw_cmd != 16'sd0 |->
            turn_left == (yaw_cmd > 16'sd0))
        else $error("search direction disagrees with tracking yaw");

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(yaw_cmd) && $stable(action))
        else $error("stalled command transaction changed");

endmodule

bind bbox_visual_servo_step_core bvs_checker #(.COORD_BITS(COORD_BITS)) u_bvs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .det_valid  (det.valid),
    .det_ready  (det.ready),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .action     (cmd.action),
    .yaw_cmd    (cmd.yaw_cmd),
    .climb_cmd  (cmd.climb_cmd),
    .target_col (cmd.target_col),
    .target_row (cmd.target_row),
    .turn_left  (cmd.turn_left)
);
